// ----- design/modular_exponentiation_assert.svh -----
// assertion macros used by the checker file of the modular exponentiation block
// expects i_clk and i_rst_n in the scope where the macros are used
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication, off while reset is low
`define MEXP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mexp_pkg.sv -----
// shared types and constants of the modular exponentiation block
// no dependencies; used by the interfaces, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

    // width of modulus, exponent and all internal residues
    localparam int KEY_WIDTH       = 32;
    // width of the beat fields and configuration data
    localparam int FIELD_WIDTH     = 32;
    // bit step counter of the shared multiplier
    localparam int CNT_WIDTH       = $clog2(KEY_WIDTH);
    localparam int CFG_INDEX_WIDTH = 2;

    typedef logic [KEY_WIDTH-1:0]       t_key;
    typedef logic [FIELD_WIDTH-1:0]     t_word;
    typedef logic [CNT_WIDTH-1:0]       t_cnt;
    typedef logic [CFG_INDEX_WIDTH-1:0] t_cfg_index;

    // configuration register indexes
    localparam t_cfg_index REG_MODULUS  = t_cfg_index'(0);
    localparam t_cfg_index REG_EXPONENT = t_cfg_index'(1);

    // register values after reset
    localparam t_word MODULUS_RESET  = t_word'(1003);
    localparam t_word EXPONENT_RESET = t_word'(3);

endpackage

`default_nettype wire

// ----- design/mexp_if.sv -----
// handshake interfaces of the modular exponentiation block: base, result, configuration
// depends on mexp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mexp_base_if import mexp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word base_value;

    modport source (output valid, output base_value, input ready);
    modport sink   (input valid, input base_value, output ready);
endinterface

interface mexp_result_if import mexp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

interface mexp_cfg_if import mexp_pkg::*; ();
    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_word      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/modular_exponentiation.sv -----
// top level of the modular exponentiation block: sequencer and shared modular multiplier
// depends on mexp_pkg and the interfaces in mexp_if.sv
// ---------------------------------------------------------------------------------------------
// Computes base_value^exponent mod modulus by right-to-left binary square-and-multiply, the
// modulus and exponent being key values that the user must write through the configuration
// port only while the block is idle; the block itself does not enforce this (index 0 modulus,
// index 1 exponent; other indexes are ignored; the port is always ready). One shared
// bit-serial modular multiplier does all the work: it forms each product one multiplier bit
// per cycle (double, then add when the bit is set, each followed by a conditional subtract of
// the modulus). An item first spends one product reducing the base below the modulus, then
// one square per exponent bit above the lowest and one multiply per set exponent bit. A zero
// exponent or a zero modulus needs no products. The base side takes one beat at a time and is
// ready again as soon as the result sits in the output register, so the next item may start
// while that result waits. Zero exponent gives 1 for any modulus, a zero modulus gives 0
// otherwise, a modulus of one gives 0.
// ---------------------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation import mexp_pkg::*; (
    input  wire            i_clk,
    input  wire            i_rst_n,
    mexp_base_if.sink      i_base,
    mexp_result_if.source  o_result,
    mexp_cfg_if.sink       i_cfg
);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for a base beat
    localparam logic [2:0] S_RED  = 3'd1;   // base mod modulus
    localparam logic [2:0] S_MUL  = 3'd2;   // accumulator times running square
    localparam logic [2:0] S_SQR  = 3'd3;   // running square squared
    localparam logic [2:0] S_DONE = 3'd4;   // hand the accumulator to the output register

    localparam t_cnt CNT_LAST = t_cnt'(KEY_WIDTH - 1);
    localparam t_key KEY_ONE  = t_key'(1);

    // configuration
    t_key r_mod, n_mod;
    t_key r_exp, n_exp;

    // sequencer and working state
    logic [2:0] r_state, n_state;
    t_key       r_acc,  n_acc;      // running product
    t_key       r_sq,   n_sq;       // running square of the base
    t_key       r_esh,  n_esh;      // exponent bits not yet scanned

    // shared multiplier: r_prod = (r_x * multiplier bits seen so far) mod r_mod
    t_key r_prod, n_prod;
    t_key r_x,    n_x;              // multiplicand, always below the modulus
    t_key r_y,    n_y;              // multiplier, shifted out msb first
    t_cnt r_cnt,  n_cnt;

    // output register
    logic  r_out_valid, n_out_valid;
    t_word r_out_data,  n_out_data;

    // one multiplier step: double mod m, then add x mod m when the multiplier bit is set
    logic [KEY_WIDTH:0] w_mod_ext;
    logic [KEY_WIDTH:0] w_dbl;
    t_key               w_dbl_red;
    logic [KEY_WIDTH:0] w_sum;
    t_key               w_sum_red;
    t_key               w_step;
    logic               w_last;

    assign w_mod_ext = {1'b0, r_mod};
    assign w_dbl     = {r_prod, 1'b0};
    assign w_dbl_red = (w_dbl >= w_mod_ext) ? t_key'(w_dbl - w_mod_ext) : t_key'(w_dbl);
    assign w_sum     = {1'b0, w_dbl_red} + {1'b0, r_x};
    assign w_sum_red = (w_sum >= w_mod_ext) ? t_key'(w_sum - w_mod_ext) : t_key'(w_sum);
    assign w_step    = r_y[KEY_WIDTH-1] ? w_sum_red : w_dbl_red;
    assign w_last    = (r_cnt == '0);

    assign i_base.ready      = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_result.valid        = r_out_valid;
    assign o_result.power_result = r_out_data;

    always_comb begin
        n_mod       = r_mod;
        n_exp       = r_exp;
        n_state     = r_state;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_esh       = r_esh;
        n_prod      = r_prod;
        n_x         = r_x;
        n_y         = r_y;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // config beats
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MODULUS:  n_mod = t_key'(i_cfg.data);
                REG_EXPONENT: n_exp = t_key'(i_cfg.data);
                default: ;
            endcase
        end

        // result beat taken
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        // multiplier runs in every working state
        if (r_state inside {S_RED, S_MUL, S_SQR}) begin
            n_prod = w_step;
            n_y    = r_y << 1;
            n_cnt  = r_cnt - t_cnt'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (i_base.valid) begin
                    n_esh  = r_exp;
                    n_prod = '0;
                    n_cnt  = CNT_LAST;
                    if (r_mod == '0 || r_exp == '0) begin
                        // no products needed
                        n_acc   = (r_exp == '0) ? KEY_ONE : '0;
                        n_state = S_DONE;
                    end else begin
                        // base times (1 mod m) reduces the base
                        n_acc   = KEY_ONE;
                        n_x     = (r_mod == KEY_ONE) ? '0 : KEY_ONE;
                        n_y     = t_key'(i_base.base_value);
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                if (w_last) begin
                    n_sq   = w_step;
                    n_prod = '0;
                    n_cnt  = CNT_LAST;
                    n_x    = w_step;
                    if (r_esh[0]) begin
                        n_y     = r_acc;
                        n_state = S_MUL;
                    end else begin
                        n_y     = w_step;
                        n_state = S_SQR;
                    end
                end
            end
            S_MUL: begin
                if (w_last) begin
                    n_acc = w_step;
                    if (r_esh[KEY_WIDTH-1:1] == '0) begin
                        // last set bit: the final square would be unused
                        n_state = S_DONE;
                    end else begin
                        n_prod  = '0;
                        n_cnt   = CNT_LAST;
                        n_x     = r_sq;
                        n_y     = r_sq;
                        n_state = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (w_last) begin
                    n_sq   = w_step;
                    n_esh  = r_esh >> 1;
                    n_prod = '0;
                    n_cnt  = CNT_LAST;
                    n_x    = w_step;
                    // squares only run while higher bits remain, so the new lsb is r_esh[1]
                    if (r_esh[1]) begin
                        n_y     = r_acc;
                        n_state = S_MUL;
                    end else begin
                        n_y     = w_step;
                        n_state = S_SQR;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = t_word'(r_acc);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mod       <= t_key'(MODULUS_RESET);
            r_exp       <= t_key'(EXPONENT_RESET);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_mod       <= n_mod;
            r_exp       <= n_exp;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_sq       <= n_sq;
        r_esh      <= n_esh;
        r_prod     <= n_prod;
        r_x        <= n_x;
        r_y        <= n_y;
        r_cnt      <= n_cnt;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

// ----- design/mexp_checker.sv -----
// port-level checks of the modular exponentiation block, bound to the top level
// depends on mexp_pkg and modular_exponentiation_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "modular_exponentiation_assert.svh"

module mexp_checker import mexp_pkg::*; (
    input wire   i_clk,
    input wire   i_rst_n,
    input wire   i_base_valid,
    input wire   i_base_ready,
    input wire   i_result_valid,
    input wire   i_result_ready,
    input t_word i_power_result,
    input wire   i_cfg_ready
);

    // a stalled result stays offered
    `MEXP_ASSERT_NEXT(a_result_held, i_result_valid && !i_result_ready,
        i_result_valid, "result dropped while stalled")

    // a stalled result keeps its value
    `MEXP_ASSERT_NEXT(a_result_stable, i_result_valid && !i_result_ready,
        $stable(i_power_result), "result changed while stalled")

    // one item at a time: busy right after a base beat
    `MEXP_ASSERT_NEXT(a_busy_after_beat, i_base_valid && i_base_ready,
        !i_base_ready, "base taken while busy")

    // configuration never back-pressures
    `MEXP_ASSERT_NOW(a_cfg_open, 1'b1, i_cfg_ready, "config port not ready")

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_base_valid   (i_base.valid),
    .i_base_ready   (i_base.ready),
    .i_result_valid (o_result.valid),
    .i_result_ready (o_result.ready),
    .i_power_result (o_result.power_result),
    .i_cfg_ready    (i_cfg.ready)
);

`default_nettype wire

// ----- tb/sv/mexp_score_pkg.sv -----
// result tracking for the modular exponentiation testbench: key copy and queue of expected powers
// depends on mexp_pkg for the field and register index types and the register constants
`timescale 1ns / 1ps

package mexp_score_pkg;
    import mexp_pkg::*;

    // indexes that the block ignores
    localparam t_cfg_index REG_SPARE_2 = t_cfg_index'(2);
    localparam t_cfg_index REG_SPARE_3 = t_cfg_index'(3);

    class power_ledger;
        t_word key_modulus;
        t_word key_exponent;
        t_word expected_powers[$];
        int    mismatches;
        int    bases_noted;
        int    results_checked;

        function new();
            key_modulus     = MODULUS_RESET;
            key_exponent    = EXPONENT_RESET;
            mismatches      = 0;
            bases_noted     = 0;
            results_checked = 0;
        endfunction

        function void set_register(t_cfg_index idx, t_word value);
            case (idx)
                REG_MODULUS:  key_modulus  = value;
                REG_EXPONENT: key_exponent = value;
                default:      ;
            endcase
        endfunction

        // base^exponent mod modulus, square-and-multiply from the low exponent bit
        function t_word power_mod(t_word base);
            logic [63:0] acc;
            logic [63:0] square;
            t_word       bits_left;
            if (key_exponent == '0)
                return t_word'(1);
            if (key_modulus == '0)
                return '0;
            acc       = 64'd1;
            square    = 64'(base) % 64'(key_modulus);
            bits_left = key_exponent;
            while (bits_left != '0) begin
                if (bits_left[0])
                    acc = (acc * square) % 64'(key_modulus);
                square    = (square * square) % 64'(key_modulus);
                bits_left = bits_left >> 1;
            end
            return t_word'(acc);
        endfunction

        function void note_base(t_word base);
            expected_powers.push_back(power_mod(base));
            bases_noted++;
        endfunction

        function void check_result(t_word actual);
            t_word wanted;
            results_checked++;
            if (expected_powers.size() == 0) begin
                $display("%0t: power_result with none pending, expected none actual %h",
                         $time, actual);
                mismatches++;
            end else begin
                wanted = expected_powers.pop_front();
                if (actual !== wanted) begin
                    $display("%0t: power_result expected %h actual %h", $time, wanted, actual);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_powers.size();
        endfunction
    endclass

endpackage

// ----- tb/sv/modular_exponentiation_tb.sv -----
// testbench top of the modular exponentiation block: directed keys, then random keys and bases
// depends on mexp_pkg, the interfaces in mexp_if.sv, mexp_score_pkg and the block itself
`timescale 1ns / 1ps

module modular_exponentiation_tb;
    import mexp_pkg::*;
    import mexp_score_pkg::*;

    localparam int STALL_LIMIT   = 30000;  // cycles with no beat on any channel
    localparam int HOLD_CYCLES   = 3000;   // long receiver hold-off
    localparam int TAIL_CYCLES   = 2100;   // about one full-exponent item
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 35;

    logic i_clk;
    logic i_rst_n;

    mexp_base_if   base_bus ();
    mexp_result_if result_bus ();
    mexp_cfg_if    cfg_bus ();

    modular_exponentiation i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_base   (base_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    power_ledger ledger;
    int  src_idle_pct  = 0;
    int  sink_idle_pct = 0;
    bit  hold_request  = 1'b0;
    int  hold_left     = 0;
    int  quiet_cycles  = 0;
    int  key_settings  = 1;

    always #10 i_clk = ~i_clk;

    function automatic bit roll(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // receiver: random stalls, plus one long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= !roll(sink_idle_pct);
        end
    end

    // result checks and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_bus.valid && result_bus.ready)
                ledger.check_result(result_bus.power_result);
            if ((result_bus.valid && result_bus.ready) || (base_bus.valid && base_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // one base beat; valid stays high into the next call unless the sender idles
    task automatic send_base(input t_word value);
        @(negedge i_clk);
        if (roll(src_idle_pct)) begin
            base_bus.valid <= 1'b0;
            do @(negedge i_clk); while (roll(src_idle_pct));
        end
        base_bus.valid      <= 1'b1;
        base_bus.base_value <= value;
        do @(posedge i_clk); while (!base_bus.ready);
        ledger.note_base(value);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_word value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        ledger.set_register(idx, value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_key(input t_word modulus, input t_word exponent);
        write_reg(REG_MODULUS, modulus);
        write_reg(REG_EXPONENT, exponent);
        key_settings++;
    endtask

    // stop offering bases and wait until every expected power has come back
    task automatic settle();
        @(negedge i_clk);
        base_bus.valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_phase(input int phase);
        t_word modulus;
        t_word exponent;
        t_word base;
        // idling: receiver-heavy, then sender-heavy, then none
        if (phase < 3) begin
            src_idle_pct  = 33;
            sink_idle_pct = 54;
        end else if (phase < 6) begin
            src_idle_pct  = 54;
            sink_idle_pct = 33;
        end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end
        case (phase % 4)
            0:       modulus = $urandom;
            1:       modulus = $urandom_range(1000, 2);
            2:       modulus = 32'hFFFF0000 | $urandom_range(16'hFFFF, 0);
            default: modulus = $urandom_range(16'hFFFF, 2);
        endcase
        // mostly moderate exponents to keep the run short, one full-width phase
        case (phase)
            1:       exponent = 32'd65537;
            2:       exponent = $urandom;
            3:       exponent = $urandom_range(8'hFF, 0);
            5:       exponent = $urandom_range(12'hFFF, 1);
            6:       exponent = $urandom_range(15, 1);
            7:       exponent = $urandom_range(20'hFFFFF, 1);
            default: exponent = $urandom_range(17'h1FFFF, 1);
        endcase
        set_key(modulus, exponent);
        if (phase == 6) begin
            // receiver holds off while bases keep coming, so the block backs up
            @(posedge i_clk);
            hold_request = 1'b1;
        end
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (modulus > 1 && $urandom_range(3, 0) == 0)
                base = $urandom_range(modulus - 1, 0);
            else
                base = $urandom;
            send_base(base);
        end
        settle();
    endtask

    initial begin
        ledger              = new();
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        base_bus.valid      = 1'b0;
        base_bus.base_value = '0;
        result_bus.ready    = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = REG_MODULUS;
        cfg_bus.data        = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 33;
        sink_idle_pct = 54;

        // reset key: bases around the modulus and at the field extremes
        send_base(32'd0);
        send_base(32'd1);
        send_base(32'd1002);
        send_base(32'd1003);
        send_base(32'd1004);
        send_base(32'hFFFFFFFF);
        settle();

        // widest key: longest exponent, base reduction at the top of the range
        set_key(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_base(32'd0);
        send_base(32'd1);
        send_base(32'hFFFFFFFE);
        send_base(32'hFFFFFFFF);
        send_base(32'h55555555);
        send_base(32'hAAAAAAAA);
        settle();

        // zero exponent with a modulus of one; writes to ignored indexes change nothing
        set_key(32'd1, 32'd0);
        write_reg(REG_SPARE_2, 32'd0);
        write_reg(REG_SPARE_3, 32'hFFFFFFFF);
        send_base(32'd0);
        send_base(32'hFFFFFFFF);
        settle();

        // modulus of one
        set_key(32'd1, 32'd65537);
        send_base(32'd5);
        send_base(32'hFFFFFFFF);
        settle();

        // zero modulus, with and without an exponent
        set_key(32'd0, 32'd7);
        send_base(32'd9);
        send_base(32'hFFFFFFFF);
        settle();
        set_key(32'd0, 32'd0);
        send_base(32'h12345678);
        settle();

        // smallest real modulus
        set_key(32'd2, 32'd1);
        send_base(32'h80000000);
        send_base(32'h7FFFFFFF);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(p);

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d bases over %0d key settings, %0d powers checked",
                 ledger.bases_noted, key_settings, ledger.results_checked);
        $display("keys ranged from zero and one up to full width, with long output stalls");
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0t: %0d mismatches, %0d powers still pending",
                     $time, ledger.mismatches, ledger.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
